FILE: hdl/asta_pkg.sv
`default_nettype none
package asta_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SPREAD_W = 4;

  // Depths of the queue between front and back and of the result queue.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // Register index of stable_spread, taken from paddr[2].
  localparam logic REG_STABLE_SPREAD = 1'b0;
  localparam logic [SPREAD_W-1:0] STABLE_SPREAD_RESET = 4'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SPREAD_W-1:0] spread_t;

  // One averaging sample on its way from front to back.
  typedef struct packed {
    sample_t sample;
    logic    last;
  } mid_item_t;

endpackage
`default_nettype wire

FILE: hdl/asta_fifo.sv
`default_nettype none
module asta_fifo #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/asta_front.sv
`default_nettype none
module asta_front #(
  parameter int AVG_SHIFT    = 3,
  parameter int WINDOW_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire asta_pkg::sample_t  sample,
  input  wire asta_pkg::spread_t  stable_spread,
  output logic                    mid_push,
  output asta_pkg::mid_item_t     mid_item
);
  import asta_pkg::*;

  localparam int CW = AVG_SHIFT + 1;
  localparam logic [CW-1:0] LAST_COUNT = CW'((1 << AVG_SHIFT) - 1);

  sample_t       window [WINDOW_DEPTH];
  sample_t       win_shift [WINDOW_DEPTH];
  logic          averaging;
  logic [CW-1:0] taken;
  sample_t       hi;
  sample_t       lo;
  sample_t       spread;
  logic          settled;
  logic          last;

  // The window as it stands once this sample is shifted in, and its spread.
  always_comb begin
    win_shift[0] = sample;
    for (int k = 1; k < WINDOW_DEPTH; k++) begin
      win_shift[k] = window[k-1];
    end
    hi = sample;
    lo = sample;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if (win_shift[k] > hi) begin
        hi = win_shift[k];
      end
      if (win_shift[k] < lo) begin
        lo = win_shift[k];
      end
    end
    spread  = hi - lo;
    settled = (spread <= {{(SAMPLE_W - SPREAD_W){1'b0}}, stable_spread});
  end

  assign last            = (taken == LAST_COUNT);
  assign mid_push        = accept && averaging;
  assign mid_item.sample = sample;
  assign mid_item.last   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '{default: '0};
      averaging <= 1'b0;
      taken     <= '0;
    end else if (accept) begin
      if (!averaging) begin
        window <= win_shift;
        if (settled) begin
          averaging <= 1'b1;
          taken     <= '0;
        end
      end else if (last) begin
        averaging <= 1'b0;
        taken     <= '0;
        window    <= '{default: '0};
      end else begin
        taken <= taken + CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/asta_back.sv
`default_nettype none
module asta_back #(
  parameter int AVG_SHIFT = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                mid_empty,
  input  wire asta_pkg::mid_item_t mid_item,
  output logic                     mid_pop,
  input  wire logic                out_full,
  output logic                     out_push,
  output asta_pkg::sample_t        out_average
);
  import asta_pkg::*;

  localparam int SW = SAMPLE_W + AVG_SHIFT;

  logic [SW-1:0] running_sum;
  logic [SW-1:0] sum_next;

  assign mid_pop     = !mid_empty && !out_full;
  assign out_push    = mid_pop && mid_item.last;
  assign sum_next    = running_sum + SW'(mid_item.sample);
  // Dropping the low AVG_SHIFT bits gives the truncated mean.
  assign out_average = sum_next[SW-1:AVG_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (mid_pop) begin
      running_sum <= mid_item.last ? '0 : sum_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/adc_settle_then_average_top.sv
`default_nettype none
// A result reaches the result ports through the queue to the back and then the result
// queue; a full result queue holds it back until popped.
// Throughput: one sample item per cycle, sustained, while results are popped.
// The front takes items, the back sums them; a four-entry queue and a two-entry
// result queue let each side stall on its own.
// Reset (rst, synchronous): window cleared to zero, settle phase, sum and count
// cleared, both queues emptied, stable_spread back to 1.
module adc_settle_then_average_top #(
  parameter int AVG_SHIFT    = 3,
  parameter int WINDOW_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Sample items in.
  input  wire logic                push,
  input  wire asta_pkg::sample_t   sample,
  output logic                     full,
  // Result items out.
  output logic                     empty,
  input  wire logic                pop,
  output asta_pkg::sample_t        average,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import asta_pkg::*;

  localparam int MID_W = $bits(mid_item_t);

  spread_t    stable_spread;
  logic       accept;
  logic       mid_push;
  mid_item_t  mid_in;
  mid_item_t  mid_out;
  logic [MID_W-1:0] mid_out_bits;
  logic       mid_full;
  logic       mid_empty;
  logic       mid_pop;
  logic       out_full;
  logic       out_push;
  sample_t    out_average;

  // The register sits at byte address 0; paddr[2] selects the register index,
  // and only index zero exists, so writes with paddr[2] set are dropped.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_spread <= STABLE_SPREAD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STABLE_SPREAD)) begin
      stable_spread <= pwdata[SPREAD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STABLE_SPREAD) begin
      prdata = {{(32 - SPREAD_W){1'b0}}, stable_spread};
    end
  end

  // The front is held off only by the queue to the back. Settle-phase items
  // never enter that queue, but holding them too keeps the phase order simple.
  assign full   = mid_full;
  assign accept = push && !mid_full;

  asta_front #(
    .AVG_SHIFT    (AVG_SHIFT),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (sample),
    .stable_spread (stable_spread),
    .mid_push      (mid_push),
    .mid_item      (mid_in)
  );

  // Averaging samples, each tagged with whether it closes its average.
  asta_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_out_bits),
    .empty     (mid_empty)
  );

  assign mid_out = mid_item_t'(mid_out_bits);

  asta_back #(
    .AVG_SHIFT (AVG_SHIFT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mid_empty   (mid_empty),
    .mid_item    (mid_out),
    .mid_pop     (mid_pop),
    .out_full    (out_full),
    .out_push    (out_push),
    .out_average (out_average)
  );

  // Finished averages wait here until popped.
  asta_fifo #(
    .WIDTH (SAMPLE_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (out_average),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (average),
    .empty     (empty)
  );

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import asta_pkg::*;

  // The block is built with its default configuration; the predictor below
  // uses the same two numbers.
  localparam int AVG_SHIFT    = 3;
  localparam int WINDOW_DEPTH = 4;

  // Register map: stable_spread sits at index 0, byte address 0. The next word
  // address names no register, so a write there must leave everything alone.
  localparam logic [2:0] ADDR_STABLE_SPREAD = {REG_STABLE_SPREAD, 2'b00};
  localparam logic [2:0] ADDR_UNLISTED      = 3'd4;

  // Phase boundaries and the end of the run wait out a generous drain.
  localparam int DRAIN_CYCLES = 20;
  // Cycles in a row with no item accepted on either side before the run is
  // declared hung. The slowest legal stretch is a phase boundary, which is
  // the drain above plus the configuration writes and readbacks.
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_PHASE_ITEMS = 300;
  localparam int MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  sample_t     sample = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  sample_t     average;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  adc_settle_then_average_top #(
    .AVG_SHIFT   (AVG_SHIFT),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .sample (sample),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .average(average),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample items waiting to be offered, and the averages the block owes us.
  sample_t samples_to_send[$];
  sample_t averages_owed[$];

  // Items queued by the stimulus and items the block has actually taken.
  // The stimulus compares the two to know that everything has gone in.
  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;

  // Percent of cycles in which each side holds back.
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  int unsigned faults = 0;
  int unsigned quiet_cycles = 0;

  // Shadow of the block: the settle window, the phase flag, the count and
  // sum of the current average, and the programmed spread.
  sample_t     shadow_window[WINDOW_DEPTH];
  bit          shadow_averaging;
  int unsigned shadow_taken;
  int unsigned shadow_sum;
  spread_t     shadow_spread;

  task automatic note_fault(input string what, input int unsigned want, input int unsigned got);
    begin
      if (faults < MAX_REPORTS) begin
        $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
      end
      faults++;
    end
  endtask

  task automatic note_fault_if_differs(input sample_t want, input sample_t got);
    begin
      if (want !== got) note_fault("average", 32'(want), 32'(got));
    end
  endtask

  task automatic shadow_clear_window();
    begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        shadow_window[k] = '0;
      end
    end
  endtask

  // Advance the shadow by one accepted sample item. In the settle phase the
  // sample shifts into the window and the window spread decides whether the
  // average phase begins; the settling sample itself is never summed. In the
  // average phase the sample is summed, and the 2^AVG_SHIFT-th one closes the
  // average, which is then owed by the block.
  task automatic settle_or_accumulate(input sample_t s);
    sample_t lo;
    sample_t hi;
    begin
      if (!shadow_averaging) begin
        for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
          shadow_window[k] = shadow_window[k-1];
        end
        shadow_window[0] = s;
        lo = s;
        hi = s;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
          if (shadow_window[k] > hi) hi = shadow_window[k];
          if (shadow_window[k] < lo) lo = shadow_window[k];
        end
        if ((hi - lo) <= shadow_spread) begin
          shadow_averaging = 1'b1;
          shadow_taken = 0;
          shadow_sum = 0;
        end
      end else begin
        shadow_sum += s;
        shadow_taken++;
        if (shadow_taken >= (1 << AVG_SHIFT)) begin
          averages_owed.push_back(sample_t'(shadow_sum >> AVG_SHIFT));
          shadow_averaging = 1'b0;
          shadow_taken = 0;
          shadow_sum = 0;
          shadow_clear_window();
        end
      end
    end
  endtask

  // Driver. A sample item stays on the port while the block is full; once it
  // has been taken, or while nothing is offered, the next one may go out
  // unless this cycle is chosen as an idle one.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
        sample <= samples_to_send.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // The result side pops at random; pop is free to be high while empty.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor. Both handshakes are sampled at the clock edge, where the values
  // driven on the previous edge are stable.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        settle_or_accumulate(sample);
        samples_taken++;
      end
      if (pop && !empty) begin
        if (averages_owed.size() == 0) begin
          note_fault("average with none owed", 0, 32'(average));
        end else begin
          note_fault_if_differs(averages_owed.pop_front(), average);
        end
      end
    end
  end

  // Watchdog: a run in which neither side moves for too long has hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL adc_settle_then_average_top");
      $finish;
    end
  end

  // Configuration write: a setup cycle, then an access cycle, with the
  // register taking the value at the edge that ends the access cycle.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    begin
      @(posedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_STABLE_SPREAD) shadow_spread = data[SPREAD_W-1:0];
      @(negedge clk);
    end
  endtask

  // Read stable_spread back and compare it with the shadow copy.
  task automatic check_spread_readback();
    begin
      @(posedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_STABLE_SPREAD;
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      if (prdata[SPREAD_W-1:0] !== shadow_spread) begin
        note_fault("stable_spread readback", 32'(shadow_spread), 32'(prdata[SPREAD_W-1:0]));
      end
      @(posedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic queue_sample(input sample_t s);
    begin
      samples_to_send.push_back(s);
      samples_queued++;
    end
  endtask

  // Hold the sender back until every queued item is in and every owed
  // average has come out, then let the block settle down.
  task automatic wait_until_drained();
    begin
      do @(negedge clk);
      while (samples_taken != samples_queued || averages_owed.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  // One random phase. Most of it is well-formed: a run that settles at the
  // current spread followed by a full set of averaging samples. The rest is
  // short runs near zero that settle against the cleared window, runs that
  // almost settle and are then broken by an outlier, and plain noise.
  task automatic queue_random_phase(input int unsigned count);
    int unsigned before_count;
    int unsigned base;
    int unsigned pick;
    int unsigned span;
    begin
      before_count = samples_queued;
      span = shadow_spread;
      while (samples_queued - before_count < count) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          base = $urandom_range(1023 - span);
          repeat (WINDOW_DEPTH + $urandom_range(1)) begin
            queue_sample(sample_t'(base + $urandom_range(span)));
          end
          repeat (1 << AVG_SHIFT) begin
            case ($urandom_range(3))
              0: queue_sample(sample_t'(1023 - $urandom_range(7)));
              1: queue_sample(sample_t'($urandom_range(7)));
              default: queue_sample(sample_t'($urandom_range(1023)));
            endcase
          end
        end else if (pick < 80) begin
          repeat (1 + $urandom_range(WINDOW_DEPTH - 2)) begin
            queue_sample(sample_t'($urandom_range(span)));
          end
        end else if (pick < 90) begin
          base = $urandom_range(1023 - span);
          repeat (WINDOW_DEPTH - 1) begin
            queue_sample(sample_t'(base + $urandom_range(span)));
          end
          if (base >= 512) queue_sample(sample_t'($urandom_range(base - span - 1)));
          else queue_sample(sample_t'(base + span + 1 + $urandom_range(1023 - base - span - 1)));
        end else begin
          repeat (1 + $urandom_range(3)) begin
            queue_sample(sample_t'($urandom_range(1023)));
          end
        end
      end
    end
  endtask

  initial begin
    int unsigned spreads[6];

    shadow_clear_window();
    shadow_averaging = 1'b0;
    shadow_taken = 0;
    shadow_sum = 0;
    shadow_spread = STABLE_SPREAD_RESET;

    // Reset is held at the start and never raised again.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 35;
    recv_idle = 72;

    // Directed part at the reset spread of 1. The window still holds its
    // reset zeros, so a zero sample settles at once; the settling sample is
    // left out of the average that follows.
    check_spread_readback();
    queue_sample(sample_t'(0));
    repeat (1 << AVG_SHIFT) queue_sample(sample_t'(1023));
    // After the clear the zeros keep a full-scale run from settling until the
    // whole window holds it.
    repeat (WINDOW_DEPTH) queue_sample(sample_t'(1023));
    repeat (1 << AVG_SHIFT) queue_sample(sample_t'(0));
    // Two samples of alternating bits close out the directed items.
    queue_sample(sample_t'(10'h2AA));
    queue_sample(sample_t'(10'h155));
    wait_until_drained();

    // A write to the address past the register list must be ignored, and
    // only the low bits of a written value count.
    reg_write(ADDR_UNLISTED, 32'hFFFF_FFFF);
    check_spread_readback();
    reg_write(ADDR_STABLE_SPREAD, 32'hFFFF_FFF0 | 32'd0);
    check_spread_readback();

    // Random phases: spreads at both extremes and in between, under the three
    // idling patterns. Each phase boundary also pauses the sender until every
    // owed average has arrived.
    spreads[0] = 0;
    spreads[1] = 15;
    spreads[2] = 3;
    spreads[3] = 0;
    spreads[4] = 15;
    spreads[5] = $urandom_range(15);
    for (int phase = 0; phase < 6; phase++) begin
      if (phase >= 4) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (phase >= 2) begin
        send_idle = 72;
        recv_idle = 35;
      end
      reg_write(ADDR_STABLE_SPREAD,
                {28'($urandom_range(32'h0FFF_FFFF)), 4'h0} | 32'(spreads[phase]));
      check_spread_readback();
      queue_random_phase(RANDOM_PHASE_ITEMS);
      wait_until_drained();
    end

    if (faults == 0) begin
      $display("PASS adc_settle_then_average_top");
    end else begin
      $display("FAIL adc_settle_then_average_top");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/asta_pkg.sv
hdl/asta_fifo.sv
hdl/asta_front.sv
hdl/asta_back.sv
hdl/adc_settle_then_average_top.sv
bench/tb_top.sv
